// ===== sv/bfiq_pkg.sv =====
package bfiq_pkg;

    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
    localparam logic [31:0] KEY_BYTES = 32'd4;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_MOD,
        ST_MEM,
        ST_CHECK,
        ST_OUT
    } state_t;

endpackage

// ===== sv/bloom_filter_insert_query.sv =====
// each hash of an item runs through the shared multiplier
// and the bit-serial modulo unit (one quotient bit per cycle)
// one item at a time: no new item until it is done and any query result is taken
// reset: synchronous active-low aresetn; after reset all MAX_BUCKETS bits of the
// mark store are cleared, one bit per cycle; no item is accepted until that is done
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int MAX_BUCKETS = 524288,
    parameter int MAX_HASHES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // operation, key
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // present
);

    localparam int AW = $clog2(MAX_BUCKETS);
    localparam int HW = $clog2(MAX_HASHES + 1);
    localparam int MW = 25;

    logic mem [MAX_BUCKETS];

    state_t state_reg, state_next;
    logic [19:0] buckets_reg;
    logic [3:0] hashes_reg;
    logic [31:0] key_reg, key_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic op_reg, op_next;
    logic [HW-1:0] idx_reg, idx_next;
    logic [HW-1:0] nh_reg, nh_next;
    logic [MW-1:0] nb_reg, nb_next;
    logic [MW:0] rem_reg, rem_next;
    logic [5:0] bit_reg, bit_next;
    logic all_reg, all_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic present_reg, present_next;
    logic rd_reg;
    logic wr_en, rd_en;
    logic [AW-1:0] addr;

    logic [31:0] mul_a, mul_y;
    logic [MW:0] rem_sh;
    logic [MW-1:0] nb_eff;
    logic [HW-1:0] nh_eff;

    assign mul_y = mul_a * MIX_MUL;
    assign rem_sh = {rem_reg[MW-1:0], h_reg[31]};

    always_comb begin
        if (buckets_reg == 20'd0) begin
            nb_eff = MW'(1);
        end else if (MW'(buckets_reg) > MW'(MAX_BUCKETS)) begin
            nb_eff = MW'(MAX_BUCKETS);
        end else begin
            nb_eff = MW'(buckets_reg);
        end
        if (32'(hashes_reg) > 32'(MAX_HASHES)) begin
            nh_eff = HW'(MAX_HASHES);
        end else begin
            nh_eff = HW'(hashes_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            buckets_reg <= 20'd524288;
            hashes_reg <= 4'd5;
            clr_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            if (cfg_we && cfg_index == REG_BUCKET_COUNT) begin
                buckets_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HASH_COUNT) begin
                hashes_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        h_reg <= h_next;
        k_reg <= k_next;
        op_reg <= op_next;
        idx_reg <= idx_next;
        nh_reg <= nh_next;
        nb_reg <= nb_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        all_reg <= all_next;
        present_reg <= present_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= (state_reg != ST_CLEAR);
        end
        if (rd_en) begin
            rd_reg <= mem[addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        key_next = key_reg;
        h_next = h_reg;
        k_next = k_reg;
        op_next = op_reg;
        idx_next = idx_reg;
        nh_next = nh_reg;
        nb_next = nb_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        all_next = all_reg;
        clr_next = clr_reg;
        present_next = present_reg;
        mul_a = k_reg;
        wr_en = 1'b0;
        rd_en = 1'b0;
        addr = rem_reg[AW-1:0];
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == MAX_BUCKETS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next = s_tdata[0];
                    key_next = s_tdata[32:1];
                    nh_next = nh_eff;
                    nb_next = nb_eff;
                    idx_next = '0;
                    all_next = 1'b1;
                    k_next = s_tdata[32:1];
                    if (nh_eff == '0) begin
                        present_next = 1'b1;
                        state_next = (s_tdata[0] == OP_QUERY) ? ST_OUT : ST_IDLE;
                    end else begin
                        state_next = ST_K1;
                    end
                end
            end
            ST_K1: begin
                mul_a = k_reg;
                k_next = mul_y ^ (mul_y >> 24);
                state_next = ST_K2;
            end
            ST_K2: begin
                mul_a = k_reg;
                k_next = mul_y;
                h_next = 32'(idx_reg) + 32'd1;
                state_next = ST_H1;
            end
            ST_H1: begin
                mul_a = h_reg ^ KEY_BYTES;
                h_next = mul_y ^ k_reg;
                state_next = ST_H2;
            end
            ST_H2: begin
                mul_a = h_reg ^ (h_reg >> 13);
                h_next = mul_y;
                state_next = ST_H3;
            end
            ST_H3: begin
                h_next = h_reg ^ (h_reg >> 15);
                rem_next = '0;
                bit_next = '0;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                h_next = {h_reg[30:0], 1'b0};
                if (rem_sh >= {1'b0, nb_reg}) begin
                    rem_next = rem_sh - {1'b0, nb_reg};
                end else begin
                    rem_next = rem_sh;
                end
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd31) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                if (op_reg == OP_INSERT) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en = 1'b1;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (op_reg == OP_QUERY && !rd_reg) begin
                    all_next = 1'b0;
                end
                idx_next = idx_reg + HW'(1);
                k_next = key_reg;
                if (idx_reg + HW'(1) == nh_reg) begin
                    present_next = all_next;
                    state_next = (op_reg == OP_QUERY) ? ST_OUT : ST_IDLE;
                end else begin
                    state_next = ST_K1;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {7'd0, present_reg};

endmodule

// ===== sv/bfiq_checker.sv =====
module bfiq_checker
    import bfiq_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_no_ready_in_reset: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("ready right after reset");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input ready while result pending");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("padding bits set");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== bench/bloom_filter_insert_query_tb.sv =====
`timescale 1ns / 1ps

module bloom_filter_insert_query_tb;
    import bfiq_pkg::*;

    localparam int MAX_BUCKETS = 524288;
    localparam int MAX_HASHES = 8;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
    } bloom_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_BUCKET_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;   // operation, key
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // present

    bloom_item_t  pending_items[$];
    bit           present_q[$];
    logic [31:0]  inserted_keys[$];
    bit           mark_store [0:MAX_BUCKETS-1];
    logic [19:0]  bucket_cfg = 20'd524288;
    logic [3:0]   hash_cfg = 4'd5;
    bloom_item_t  cur_item;
    bit           idle_on = 1'b0;
    int           send_gap = 0;
    int           stall_cnt = 0;
    int           mismatches = 0;
    int           items_sent = 0;
    int           queries_checked = 0;
    int           hits_seen = 0;

    bloom_filter_insert_query u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] murmur_hash(input logic [31:0] key, input logic [31:0] seed);
        logic [31:0] k;
        logic [31:0] h;
        k = key * MIX_MUL;
        k = k ^ (k >> 24);
        k = k * MIX_MUL;
        h = (seed ^ KEY_BYTES) * MIX_MUL;
        h = h ^ k;
        h = h ^ (h >> 13);
        h = h * MIX_MUL;
        h = h ^ (h >> 15);
        return h;
    endfunction

    task automatic apply_to_filter(input bloom_item_t it);
        int unsigned nb;
        int unsigned nh;
        int unsigned pos;
        bit          all_set;
        nb = (bucket_cfg == 0) ? 1 : ((bucket_cfg > MAX_BUCKETS) ? MAX_BUCKETS : bucket_cfg);
        nh = (hash_cfg > MAX_HASHES) ? MAX_HASHES : hash_cfg;
        all_set = 1'b1;
        for (int unsigned i = 0; i < nh; i++) begin
            pos = murmur_hash(it.key, i + 1) % nb;
            if (it.op == OP_INSERT)
                mark_store[pos] = 1'b1;
            else if (!mark_store[pos])
                all_set = 1'b0;
        end
        if (it.op == OP_QUERY)
            present_q.push_back(all_set);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_to_filter(cur_item);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= {7'b0, cur_item.key, cur_item.op};
                    s_tvalid <= 1'b1;
                    send_gap = idle_on ? $urandom_range(0, 3) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            if (present_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: present=%0d", m_tdata[0]);
            end else begin
                bit exp_present;
                exp_present = present_q.pop_front();
                queries_checked++;
                if (m_tdata[0]) hits_seen++;
                if (m_tdata !== {7'b0, exp_present}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("present mismatch: expected %0d got %h", exp_present, m_tdata);
                end
            end
            stall_cnt = idle_on ? $urandom_range(0, 3) : 0;
            m_tready <= (stall_cnt == 0);
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic add_item(input logic op, input logic [31:0] key);
        bloom_item_t it;
        it.op = op;
        it.key = key;
        pending_items.push_back(it);
        if (op == OP_INSERT)
            inserted_keys.push_back(key);
    endtask

    task automatic add_random(input int n);
        logic        op;
        logic [31:0] key;
        for (int i = 0; i < n; i++) begin
            op = 1'($urandom_range(0, 1));
            key = $urandom();
            if (op == OP_QUERY && inserted_keys.size() != 0 && $urandom_range(0, 9) < 6)
                key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            add_item(op, key);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || present_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        if (idx == REG_BUCKET_COUNT) bucket_cfg = val;
        else hash_cfg = val[3:0];
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [19:0] bc, input logic [3:0] hc, input int n);
        wait_idle();
        @(posedge aclk);
        write_reg(REG_BUCKET_COUNT, bc);
        write_reg(REG_HASH_COUNT, hc);
        idle_on = $urandom_range(0, 3) != 0;
        add_random(n);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(REG_BUCKET_COUNT, 20'd524288);
        write_reg(REG_HASH_COUNT, 4'd5);
        idle_on = 1'b1;
        add_item(OP_QUERY, 32'h0000_0000);
        add_item(OP_INSERT, 32'h0000_0000);
        add_item(OP_QUERY, 32'h0000_0000);
        add_item(OP_QUERY, 32'hffff_ffff);
        add_item(OP_INSERT, 32'hffff_ffff);
        add_item(OP_QUERY, 32'hffff_ffff);
        add_item(OP_INSERT, 32'h5555_5555);
        add_item(OP_QUERY, 32'haaaa_aaaa);
        add_item(OP_QUERY, 32'h5555_5555);
        add_item(OP_QUERY, 32'h8000_0000);
        add_item(OP_QUERY, 32'h0000_0001);
        add_item(OP_INSERT, 32'h0000_0000);

        // bucket count zero, hash count zero and oversized values in between
        run_phase(20'd1, 4'd1, 60);
        run_phase(20'd0, 4'd3, 60);
        run_phase(20'd1000, 4'd0, 50);
        run_phase(20'hfffff, 4'd15, 80);
        run_phase(20'd524288, 4'd8, 80);
        run_phase(20'd2, 4'd0, 40);
        run_phase(20'd100, 4'd2, 200);
        run_phase(20'd1000, 4'd3, 200);
        run_phase(20'd37, 4'd4, 150);
        run_phase(20'd5000, 4'd1, 200);
        run_phase(20'd65536, 4'd6, 100);
        run_phase(20'd524287, 4'd2, 120);
        wait_idle();

        $display("items sent: %0d, queries checked: %0d (%0d reported present)",
                 items_sent, queries_checked, hits_seen);
        $display("bucket counts 0 to 2^20-1, hash counts 0 to 15, mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("[bloom_filter_insert_query] OK");
        else
            $display("[bloom_filter_insert_query] ERROR");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout");
        $display("[bloom_filter_insert_query] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bfiq_pkg.sv
sv/bloom_filter_insert_query.sv
sv/bfiq_checker.sv
bench/bloom_filter_insert_query_tb.sv
